// File: design/wbcs_pkg.sv
`timescale 1ns / 1ps
package wbcs_pkg;

  localparam logic [12:0] MAX_ROW_BYTES = 13'd4096;
  localparam logic [11:0] MAX_ROWS      = 12'd2048;
  localparam logic [7:0]  WHITE_VALUE   = 8'd255;
  localparam logic [5:0]  DIV_STEPS     = 6'd35;

  typedef enum logic [1:0] {
    REG_ROW_BYTES = 2'd0,
    REG_ROW_TOTAL = 2'd1,
    REG_MAX_WHITE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    STEER_STOP     = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_STRAIGHT = 2'd2,
    STEER_RIGHT    = 2'd3
  } steer_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WAIT
  } back_state_t;

  // one finished frame, handed from accumulator to divider
  typedef struct packed {
    logic        found;
    logic [12:0] width;
    logic [23:0] count;
    logic [34:0] col_sum;
    logic [33:0] row_sum;
  } frame_t;

endpackage

// File: design/wbcs_front.sv
`timescale 1ns / 1ps
module wbcs_front
  import wbcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [12:0] width,
  input  logic [11:0] height,
  input  logic [23:0] max_count,
  input  logic        q_full,
  output logic        push,
  output frame_t      push_data
);

  logic [11:0] col_pos_r;
  logic [10:0] row_pos_r;
  logic [23:0] cnt_r;
  logic [34:0] csum_r;
  logic [33:0] rsum_r;

  logic [12:0] w_m1;
  logic [11:0] h_m1;
  logic [11:0] col_eff;
  logic [10:0] row_eff;
  logic        white;
  logic [23:0] cnt_nxt;
  logic [34:0] csum_nxt;
  logic [33:0] rsum_nxt;
  logic        last_col;
  logic        last_row;
  logic        accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign w_m1    = width - 13'd1;
  assign h_m1    = height - 12'd1;
  assign col_eff = ({1'b0, col_pos_r} >= width) ? w_m1[11:0] : col_pos_r;
  assign row_eff = ({1'b0, row_pos_r} >= height) ? h_m1[10:0] : row_pos_r;

  assign white    = (in_tdata == WHITE_VALUE);
  assign cnt_nxt  = (white && (cnt_r != '1)) ? cnt_r + 24'd1 : cnt_r;
  assign csum_nxt = white ? csum_r + {23'd0, col_eff} : csum_r;
  assign rsum_nxt = white ? rsum_r + {23'd0, row_eff} : rsum_r;

  assign last_col = (({1'b0, col_eff} + 13'd1) >= width);
  assign last_row = (({1'b0, row_eff} + 12'd1) >= height);

  assign push = accept && last_col && last_row;
  assign push_data.found   = (cnt_nxt != 24'd0) && (cnt_nxt <= max_count);
  assign push_data.width   = width;
  assign push_data.count   = cnt_nxt;
  assign push_data.col_sum = csum_nxt;
  assign push_data.row_sum = rsum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      cnt_r     <= '0;
      csum_r    <= '0;
      rsum_r    <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col_pos_r <= col_eff + 12'd1;
        row_pos_r <= row_eff;
        cnt_r     <= cnt_nxt;
        csum_r    <= csum_nxt;
        rsum_r    <= rsum_nxt;
      end else if (!last_row) begin
        col_pos_r <= '0;
        row_pos_r <= row_eff + 11'd1;
        cnt_r     <= cnt_nxt;
        csum_r    <= csum_nxt;
        rsum_r    <= rsum_nxt;
      end else begin
        col_pos_r <= '0;
        row_pos_r <= '0;
        cnt_r     <= '0;
        csum_r    <= '0;
        rsum_r    <= '0;
      end
    end
  end

endmodule

// File: design/wbcs_queue.sv
`timescale 1ns / 1ps
module wbcs_queue
  import wbcs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output frame_t pop_data,
  output logic   empty
);

  frame_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// File: design/wbcs_back.sv
`timescale 1ns / 1ps
module wbcs_back
  import wbcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  frame_t      q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [11:0] out_col,
  output logic [10:0] out_row,
  output steer_t      out_steer
);

  back_state_t state_r, state_nxt;

  logic        found_r;
  logic [23:0] n_r;
  logic [34:0] csum_r;
  logic [36:0] prod_r;
  logic [34:0] cdvd_r;
  logic [34:0] rdvd_r;
  logic [23:0] crem_r;
  logic [23:0] rrem_r;
  logic [5:0]  step_r;

  logic        out_valid_r;
  logic        out_found_r;
  logic [11:0] out_col_r;
  logic [10:0] out_row_r;
  steer_t      out_steer_r;

  logic [24:0] crem_ext;
  logic [24:0] rrem_ext;
  logic        cge;
  logic        rge;
  logic [24:0] crem_sub;
  logic [24:0] rrem_sub;
  logic [37:0] c3;
  steer_t      steer_calc;
  logic        out_free;
  logic        load_out;

  assign out_free = !out_valid_r || out_ready;

  // restoring division step, one quotient bit per cycle on both sums
  assign crem_ext = {crem_r, cdvd_r[34]};
  assign rrem_ext = {rrem_r, rdvd_r[34]};
  assign cge      = (crem_ext >= {1'b0, n_r});
  assign rge      = (rrem_ext >= {1'b0, n_r});
  assign crem_sub = crem_ext - {1'b0, n_r};
  assign rrem_sub = rrem_ext - {1'b0, n_r};

  assign c3 = {2'b00, csum_r, 1'b0} + {3'b000, csum_r};

  always_comb begin
    if (!found_r) begin
      steer_calc = STEER_STOP;
    end else if (c3 < {1'b0, prod_r}) begin
      steer_calc = STEER_LEFT;
    end else if (c3 >= {prod_r, 1'b0}) begin
      steer_calc = STEER_RIGHT;
    end else begin
      steer_calc = STEER_STRAIGHT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          state_nxt = q_data.found ? BK_DIV : BK_WAIT;
        end
      end
      BK_DIV: begin
        if (step_r == DIV_STEPS - 6'd1) begin
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      found_r <= q_data.found;
      n_r     <= q_data.count;
      csum_r  <= q_data.col_sum;
      prod_r  <= 37'(q_data.width) * 37'(q_data.count);
      cdvd_r  <= q_data.col_sum;
      rdvd_r  <= {1'b0, q_data.row_sum};
      crem_r  <= '0;
      rrem_r  <= '0;
      step_r  <= '0;
    end else if (state_r == BK_DIV) begin
      cdvd_r <= {cdvd_r[33:0], cge};
      rdvd_r <= {rdvd_r[33:0], rge};
      crem_r <= cge ? crem_sub[23:0] : crem_ext[23:0];
      rrem_r <= rge ? rrem_sub[23:0] : rrem_ext[23:0];
      step_r <= step_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= found_r;
      out_col_r   <= found_r ? cdvd_r[11:0] : 12'd0;
      out_row_r   <= found_r ? rdvd_r[10:0] : 11'd0;
      out_steer_r <= steer_calc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_steer = out_steer_r;

endmodule

// File: design/white_blob_centroid_steer_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    in_tdata: pixel_byte
// out_     out  out_tvalid/out_tready  out_tdata: centroid_col, centroid_row, steer_code
//                                      out_tuser: ball_found
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One pixel per cycle is accepted while the frame queue has room.
// Each frame end with a blob found runs the restoring divider over both sums,
// then loads and hands over its result; frames that arrive faster than that stall
// the input once the two-entry frame queue fills.
// Reset (rst_n, synchronous) restores 640 x 480 geometry and limit 17000.
// cfg_ready is always high.
module white_blob_centroid_steer_top
  import wbcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] centroid_col, [22:12] centroid_row,
                                  // [24:23] steer_code, [31:25] zero
  output logic        out_tuser,  // [0] ball_found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [12:0] row_bytes_r;
  logic [11:0] row_total_r;
  logic [23:0] max_white_r;

  logic [12:0] width;
  logic [11:0] height;

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  frame_t      push_data;
  frame_t      pop_data;

  logic        out_found;
  logic [11:0] out_col;
  logic [10:0] out_row;
  steer_t      out_steer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= 13'd640;
      row_total_r <= 12'd480;
      max_white_r <= 24'd17000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_BYTES: row_bytes_r <= cfg_data[12:0];
        REG_ROW_TOTAL: row_total_r <= cfg_data[11:0];
        REG_MAX_WHITE: max_white_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width  = (row_bytes_r == 13'd0) ? 13'd1 :
                  (row_bytes_r > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_bytes_r;
  assign height = (row_total_r == 12'd0) ? 12'd1 :
                  (row_total_r > MAX_ROWS) ? MAX_ROWS : row_total_r;

  wbcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .width     (width),
    .height    (height),
    .max_count (max_white_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  wbcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  wbcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (out_found),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_steer (out_steer)
  );

  assign out_tuser = out_found;
  assign out_tdata = {7'd0, out_steer, out_row, out_col};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !pop)
    else $error("frame queue read while empty");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("not-found result carries nonzero payload");

  a_found_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_steer != STEER_STOP))
    else $error("found result with stop code");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import wbcs_pkg::*;

  localparam int unsigned RAND_PIXELS   = 1150;
  localparam int unsigned PARK_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 3 * (DIV_STEPS + 2);
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic        found;
    logic [11:0] col;
    logic [10:0] row;
    steer_t      steer;
  } blob_report_t;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_PIX,
    STEP_PIX_CHECK
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t   kind;
    logic [1:0]   idx;
    logic [23:0]  value;
    blob_report_t want;
  } plan_step_t;

  localparam blob_report_t NO_BLOB = '{1'b0, 12'd0, 11'd0, STEER_STOP};

  // pixel rows carry the byte in value[7:0]; check rows close a frame
  localparam plan_step_t PLAN [0:33] = '{
    '{STEP_CFG,       REG_ROW_BYTES, 24'd3,       NO_BLOB},
    '{STEP_CFG,       REG_ROW_TOTAL, 24'd1,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX_CHECK, 2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX_CHECK, 2'd0,          24'd0,       '{1'b1, 12'd0, 11'd0, STEER_LEFT}},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX_CHECK, 2'd0,          24'd0,       '{1'b1, 12'd1, 11'd0, STEER_STRAIGHT}},
    '{STEP_PIX,       2'd0,          24'd254,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX_CHECK, 2'd0,          24'd255,     '{1'b1, 12'd2, 11'd0, STEER_RIGHT}},
    '{STEP_CFG,       REG_MAX_WHITE, 24'd0,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX_CHECK, 2'd0,          24'd255,     NO_BLOB},
    '{STEP_CFG,       REG_ROW_BYTES, 24'hFFE000,  NO_BLOB},
    '{STEP_CFG,       REG_ROW_TOTAL, 24'hFFF000,  NO_BLOB},
    '{STEP_CFG,       REG_MAX_WHITE, 24'hFFFFFF,  NO_BLOB},
    '{STEP_CFG,       REG_UNUSED,    24'h000000,  NO_BLOB},
    '{STEP_PIX_CHECK, 2'd0,          24'd255,     '{1'b1, 12'd0, 11'd0, STEER_LEFT}},
    '{STEP_PIX_CHECK, 2'd0,          24'd0,       NO_BLOB},
    '{STEP_CFG,       REG_ROW_BYTES, 24'd4,       NO_BLOB},
    '{STEP_CFG,       REG_ROW_TOTAL, 24'd2,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_CFG,       REG_ROW_BYTES, 24'd2,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd255,     NO_BLOB},
    '{STEP_PIX,       2'd0,          24'd0,       NO_BLOB}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  white_blob_centroid_steer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // tracker copy: geometry, limit and running frame sums
  logic [12:0]  geo_cols    = 13'd640;
  logic [11:0]  geo_rows    = 12'd480;
  logic [23:0]  white_limit = 24'd17000;
  logic [11:0]  px_col      = '0;
  logic [10:0]  px_row      = '0;
  logic [23:0]  whites      = '0;
  logic [34:0]  col_acc     = '0;
  logic [33:0]  row_acc     = '0;

  blob_report_t pending_blobs [$];
  blob_report_t head_blob;
  int unsigned  faults = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;
  bit           park_receiver = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void log_fault(string what);
    faults++;
    if (faults <= 10) $display("%0t MISMATCH %s", $time, what);
  endfunction

  task automatic track_pixel(input logic [7:0] px, output bit done, output blob_report_t rep);
    int unsigned     w;
    int unsigned     h;
    longint unsigned n;
    longint unsigned cs;
    w = clamp_dim(geo_cols, MAX_ROW_BYTES);
    h = clamp_dim(geo_rows, MAX_ROWS);
    done = 1'b0;
    rep = NO_BLOB;
    // geometry may have shrunk under a frame in progress
    if (px_col >= w) px_col = 12'(w - 1);
    if (px_row >= h) px_row = 11'(h - 1);
    if (px == WHITE_VALUE) begin
      if (whites != '1) whites++;
      col_acc = col_acc + 35'(px_col);
      row_acc = row_acc + 34'(px_row);
    end
    if (px_col + 1 < w) begin
      px_col++;
    end else begin
      px_col = '0;
      if (px_row + 1 < h) begin
        px_row++;
      end else begin
        done = 1'b1;
        n = 64'(whites);
        cs = 64'(col_acc);
        if (n != 0 && n <= 64'(white_limit)) begin
          rep.found = 1'b1;
          rep.col = 12'(cs / n);
          rep.row = 11'(64'(row_acc) / n);
          if (3 * cs < w * n) rep.steer = STEER_LEFT;
          else if (3 * cs >= 2 * w * n) rep.steer = STEER_RIGHT;
          else rep.steer = STEER_STRAIGHT;
        end
        px_row = '0;
        whites = '0;
        col_acc = '0;
        row_acc = '0;
      end
    end
  endtask

  task automatic send_pixel(input logic [7:0] px, input bit typed, input blob_report_t typed_rep);
    int unsigned  gap;
    bit           done;
    blob_report_t rep;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    track_pixel(px, done, rep);
    if (done) pending_blobs.insert(pending_blobs.size(), typed ? typed_rep : rep);
  endtask

  task automatic feed(input int unsigned n, input int unsigned pct);
    logic [7:0] px;
    repeat (n) begin
      if ($urandom_range(0, 99) < pct) px = WHITE_VALUE;
      else px = 8'($urandom_range(0, 254));
      send_pixel(px, 1'b0, NO_BLOB);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROW_BYTES: geo_cols = data[12:0];
      REG_ROW_TOTAL: geo_rows = data[11:0];
      REG_MAX_WHITE: white_limit = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain every pending report, then let the divider go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_blobs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic small_phase(output int unsigned n_px);
    int unsigned r;
    int unsigned frame_px;
    int unsigned pct;
    logic [23:0] v;
    settle();
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      v = 24'($urandom);
      v[12:0] = (r < 6) ? 13'd0 : (r < 90) ? 13'($urandom_range(1, 12))
                                            : 13'($urandom_range(13, 40));
      write_reg(REG_ROW_BYTES, v);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      v = 24'($urandom);
      v[11:0] = (r < 6) ? 12'd0 : (r < 90) ? 12'($urandom_range(1, 6))
                                            : 12'($urandom_range(7, 12));
      write_reg(REG_ROW_TOTAL, v);
    end
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 4))
        0: v = 24'($urandom_range(0, 4));
        1: v = 24'($urandom_range(0, 40));
        2: v = 24'hFFFFFF;
        3: v = 24'd8388608;
        default: v = 24'($urandom);
      endcase
      write_reg(REG_MAX_WHITE, v);
    end
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 24'($urandom));
    case ($urandom_range(0, 4))
      0: pct = 0;
      1: pct = 5;
      2: pct = 30;
      3: pct = 70;
      default: pct = 100;
    endcase
    frame_px = clamp_dim(geo_cols, MAX_ROW_BYTES) * clamp_dim(geo_rows, MAX_ROWS);
    n_px = $urandom_range(1, 3 * frame_px + 2);
    if (n_px > 400) n_px = 400;
    feed(n_px, pct);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (park_receiver) begin
        park_receiver = 1'b0;
        hold = PARK_CYCLES;
      end else if (hold == 0) begin
        hold = pick_gap();
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blobs.size() == 0) begin
        log_fault($sformatf("result with nothing pending: tdata=%h tuser=%b",
                            out_tdata, out_tuser));
      end else begin
        head_blob = pending_blobs.pop_front();
        if (out_tuser !== head_blob.found || out_tdata[11:0] !== head_blob.col ||
            out_tdata[22:12] !== head_blob.row || out_tdata[24:23] !== head_blob.steer)
          log_fault($sformatf("exp found=%0d col=%0d row=%0d steer=%0d got found=%0d col=%0d row=%0d steer=%0d",
                              head_blob.found, head_blob.col, head_blob.row, head_blob.steer,
                              out_tuser, out_tdata[11:0], out_tdata[22:12], out_tdata[24:23]));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned rand_px;
    int unsigned n_px;
    rand_px = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_CFG) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else begin
        send_pixel(PLAN[i].value[7:0], PLAN[i].kind == STEP_PIX_CHECK, PLAN[i].want);
      end
    end

    // one-pixel frames with the sink parked: frame queue fills, input backs up
    settle();
    write_reg(REG_ROW_BYTES, 24'd1);
    write_reg(REG_ROW_TOTAL, 24'd1);
    write_reg(REG_MAX_WHITE, 24'hFFFFFF);
    calm = 1'b1;
    park_receiver = 1'b1;
    feed(60, 50);
    calm = 1'b0;

    // oversized row clamps to the widest; shrink mid-frame to close it at column 300
    settle();
    write_reg(REG_ROW_BYTES, 24'd8191);
    write_reg(REG_ROW_TOTAL, 24'd1);
    write_reg(REG_MAX_WHITE, 24'd8388608);
    feed(300, 30);
    settle();
    write_reg(REG_ROW_BYTES, 24'd301);
    send_pixel(WHITE_VALUE, 1'b0, NO_BLOB);
    // oversized frame clamps to the tallest; shrink mid-frame to close it at row 200
    settle();
    write_reg(REG_ROW_BYTES, 24'd1);
    write_reg(REG_ROW_TOTAL, 24'd4095);
    write_reg(REG_MAX_WHITE, 24'hFFFFFF);
    feed(200, 100);
    settle();
    write_reg(REG_ROW_TOTAL, 24'd201);
    send_pixel(WHITE_VALUE, 1'b0, NO_BLOB);
    settle();
    write_reg(REG_ROW_BYTES, 24'd3);
    write_reg(REG_ROW_TOTAL, 24'd2);

    while (rand_px < RAND_PIXELS) begin
      small_phase(n_px);
      rand_px += n_px;
    end
    settle();

    if (faults == 0 && pending_blobs.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
